// ===== rtl/assert_macros.svh =====
// assertion macros used by the checker file
// expects a clock and an active-high synchronous reset in scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// property checked on every rising edge, reset included
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

// ===== rtl/i2cms_pkg.sv =====
// shared types and constants for the i2c master bit sequencer
// no dependencies
package i2cms_pkg;

  // command codes carried in the op field
  localparam logic [2:0] OP_TICK      = 3'd0;
  localparam logic [2:0] OP_START     = 3'd1;
  localparam logic [2:0] OP_STOP      = 3'd2;
  localparam logic [2:0] OP_WRITE     = 3'd3;
  localparam logic [2:0] OP_READ_ACK  = 3'd4;
  localparam logic [2:0] OP_READ_NACK = 3'd5;

  // final phase of each sequence
  localparam logic [4:0] LAST_START = 5'd1;
  localparam logic [4:0] LAST_STOP  = 5'd2;
  localparam logic [4:0] LAST_BYTE  = 5'd18;

  // phases of the byte sequences
  localparam logic [4:0] PH_ACK_SLOT = 5'd16;
  localparam logic [4:0] PH_ACK_SAMP = 5'd17;

  localparam logic [2:0] BIT_MSB = 3'd7;

  // classified item passed from front to back through the queue
  typedef struct packed {
    logic       is_cmd;
    logic [2:0] op;
    logic [7:0] tx_byte;
    logic       sda_level;
  } item_t;

endpackage

// ===== rtl/i2cms_if.sv =====
// channel interfaces for items in and results out
// depends on nothing
interface i2cms_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] op;
  logic [7:0] tx_byte;
  logic       sda_level;

  modport source (output valid, op, tx_byte, sda_level, input ready);
  modport sink   (input valid, op, tx_byte, sda_level, output ready);
endinterface

interface i2cms_out_if;
  logic       valid;
  logic       ready;
  logic       scl_low;
  logic       sda_low;
  logic       busy_res;
  logic       done_res;
  logic [7:0] rx_byte;
  logic       ack_received;
  logic       rejected;

  modport source (output valid, scl_low, sda_low, busy_res, done_res, rx_byte,
                  ack_received, rejected, input ready);
  modport sink   (input valid, scl_low, sda_low, busy_res, done_res, rx_byte,
                  ack_received, rejected, output ready);
endinterface

// ===== rtl/i2c_master_bit_sequencer_top.sv =====
// i2c master bit sequencer, top level
// depends on i2cms_pkg, i2cms_if, i2cms_front, i2cms_fifo, i2cms_back
//
// usage
//   item channel: op (0 tick, 1 start, 2 stop, 3 write, 4 read+ack,
//   5 read+nack), tx_byte for writes and the sampled sda_level. Each
//   transaction gives exactly one transaction on the result channel with
//   the scl/sda low-enables, busy, done, the last received byte, the last
//   ack level and a rejected flag for a command sent while busy.
//   A command only latches; each later tick moves the bus one phase
//   (start 2 ticks, stop 3, byte commands 19).
// timing
//   one item per cycle sustained while results are taken; the front
//   writes the queue on the accepting edge and the sequencer registers
//   the result from the queue head, so each item passes the queue and
//   then the result register. One phase update per item sets that rate.
// reset
//   rst is synchronous; it empties the queue and the result register,
//   idles the sequencer and releases both bus lines.
// stall
//   while the result is not taken the queue fills (QUEUE_DEPTH items),
//   then item.ready drops; nothing is lost or repeated.
module i2c_master_bit_sequencer_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  i2cms_in_if.sink     item,
  i2cms_out_if.source  result
);

  logic              push;
  logic              full;
  logic              pop;
  logic              not_empty;
  i2cms_pkg::item_t  push_item;
  i2cms_pkg::item_t  pop_item;

  // classify incoming items
  i2cms_front u_front (
    .item      (item),
    .full      (full),
    .push      (push),
    .push_item (push_item)
  );

  // decoupling queue
  i2cms_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .pop_item  (pop_item)
  );

  // phase sequencer and result register
  i2cms_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (not_empty),
    .q_item  (pop_item),
    .q_pop   (pop),
    .result  (result)
  );

endmodule

// ===== rtl/i2cms_front.sv =====
// front end: accepts items and classifies them as commands or ticks
// depends on i2cms_pkg and i2cms_in_if
module i2cms_front (
  i2cms_in_if.sink          item,
  input  logic              full,
  output logic              push,
  output i2cms_pkg::item_t  push_item
);

  // accept whenever the queue has room
  assign item.ready = !full;
  assign push       = item.valid && !full;

  // op codes six and seven fall through as ticks
  always_comb begin
    push_item.is_cmd    = (item.op >= i2cms_pkg::OP_START) &&
                          (item.op <= i2cms_pkg::OP_READ_NACK);
    push_item.op        = item.op;
    push_item.tx_byte   = item.tx_byte;
    push_item.sda_level = item.sda_level;
  end

endmodule

// ===== rtl/i2cms_fifo.sv =====
// small queue between front and back
// depends on i2cms_pkg
module i2cms_fifo #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  i2cms_pkg::item_t  push_item,
  output logic              full,
  input  logic              pop,
  output logic              not_empty,
  output i2cms_pkg::item_t  pop_item
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  i2cms_pkg::item_t mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full      = (count == CNT_FULL);
  assign not_empty = (count != '0);
  assign pop_item  = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/i2cms_back.sv =====
// back end: runs the bus phase sequencer and holds the result register
// depends on i2cms_pkg and i2cms_out_if
module i2cms_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  i2cms_pkg::item_t  q_item,
  output logic              q_pop,
  i2cms_out_if.source       result
);

  // sequencer state
  logic [2:0] cmd, cmd_next;
  logic [4:0] phase, phase_next;
  logic [7:0] shreg, shreg_next;
  logic [7:0] rxb, rxb_next;
  logic       ack, ack_next;
  logic       scl, scl_next;
  logic       sda, sda_next;
  logic       done_next;
  logic       rej_next;
  logic [4:0] last_phase;
  logic [2:0] bit_idx;
  logic       out_valid;

  // take the next item when the result register is free or being emptied
  assign q_pop = q_valid && (!out_valid || result.ready);

  assign bit_idx = i2cms_pkg::BIT_MSB - phase[3:1];

  always_comb begin
    priority if (cmd == i2cms_pkg::OP_START) begin
      last_phase = i2cms_pkg::LAST_START;
    end else if (cmd == i2cms_pkg::OP_STOP) begin
      last_phase = i2cms_pkg::LAST_STOP;
    end else begin
      last_phase = i2cms_pkg::LAST_BYTE;
    end
  end

  // next state for one transaction
  always_comb begin
    cmd_next   = cmd;
    phase_next = phase;
    shreg_next = shreg;
    rxb_next   = rxb;
    ack_next   = ack;
    scl_next   = scl;
    sda_next   = sda;
    done_next  = 1'b0;
    rej_next   = 1'b0;
    if (q_item.is_cmd) begin
      if (cmd != i2cms_pkg::OP_TICK) begin
        rej_next = 1'b1;
      end else begin
        cmd_next   = q_item.op;
        phase_next = '0;
        shreg_next = (q_item.op == i2cms_pkg::OP_WRITE) ? q_item.tx_byte : 8'h00;
      end
    end else if (cmd != i2cms_pkg::OP_TICK) begin
      // one bus phase
      priority if (cmd == i2cms_pkg::OP_START) begin
        if (phase == '0) sda_next = 1'b1;
        else scl_next = 1'b1;
      end else if (cmd == i2cms_pkg::OP_STOP) begin
        priority if (phase == 5'd0) sda_next = 1'b0 | 1'b1;
        else if (phase == 5'd1) scl_next = 1'b0;
        else sda_next = 1'b0;
      end else if (cmd == i2cms_pkg::OP_WRITE) begin
        priority if (!phase[4]) begin
          if (!phase[0]) begin
            scl_next = 1'b1;
            sda_next = !shreg[bit_idx];
          end else begin
            scl_next = 1'b0;
          end
        end else if (phase == i2cms_pkg::PH_ACK_SLOT) begin
          sda_next = 1'b0;
          scl_next = 1'b1;
        end else if (phase == i2cms_pkg::PH_ACK_SAMP) begin
          scl_next = 1'b0;
          ack_next = !q_item.sda_level;
        end else begin
          scl_next = 1'b1;
        end
      end else begin
        // read with ack or nack
        priority if (!phase[4]) begin
          if (!phase[0]) begin
            if (phase != '0) scl_next = 1'b1;
          end else begin
            scl_next   = 1'b0;
            shreg_next = {shreg[6:0], q_item.sda_level};
          end
        end else if (cmd == i2cms_pkg::OP_READ_ACK) begin
          priority if (phase == i2cms_pkg::PH_ACK_SLOT) begin
            scl_next = 1'b1;
            sda_next = 1'b1;
          end else if (phase == i2cms_pkg::PH_ACK_SAMP) begin
            scl_next = 1'b0;
          end else begin
            sda_next = 1'b0;
          end
        end else begin
          scl_next = (phase != i2cms_pkg::PH_ACK_SAMP);
        end
        if (phase == i2cms_pkg::LAST_BYTE) rxb_next = shreg;
      end
      // end of sequence or next phase
      if (phase >= last_phase) begin
        cmd_next   = i2cms_pkg::OP_TICK;
        phase_next = '0;
        done_next  = 1'b1;
      end else begin
        phase_next = phase + 1'b1;
      end
    end
  end

  // state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd       <= i2cms_pkg::OP_TICK;
      phase     <= '0;
      shreg     <= '0;
      rxb       <= '0;
      ack       <= 1'b0;
      scl       <= 1'b0;
      sda       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        cmd                 <= cmd_next;
        phase               <= phase_next;
        shreg               <= shreg_next;
        rxb                 <= rxb_next;
        ack                 <= ack_next;
        scl                 <= scl_next;
        sda                 <= sda_next;
        out_valid           <= 1'b1;
        result.scl_low      <= scl_next;
        result.sda_low      <= sda_next;
        result.busy_res     <= (cmd_next != i2cms_pkg::OP_TICK);
        result.done_res     <= done_next;
        result.rx_byte      <= rxb_next;
        result.ack_received <= ack_next;
        result.rejected     <= rej_next;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign result.valid = out_valid;

endmodule

// ===== rtl/i2cms_checker.sv =====
// port-level checks for the i2c master bit sequencer
// depends on assert_macros.svh; bound to i2c_master_bit_sequencer_top
`include "assert_macros.svh"

module i2cms_checker (
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_ready,
  input logic busy_res,
  input logic done_res,
  input logic rejected
);

  // a waiting result stays until taken
  `ASSERT_CLK(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid)

  // the transaction that ends a command leaves the block idle
  `ASSERT_CLK(a_done_idle, clk, rst, out_valid && done_res |-> !busy_res)

  // a rejected command only happens mid-sequence and never ends it
  `ASSERT_CLK(a_rej_busy, clk, rst, out_valid && rejected |-> busy_res && !done_res)

  // nothing is shown right after reset
  `ASSERT_ALWAYS(a_rst_clear, clk, $past(rst) |-> !out_valid)

endmodule

bind i2c_master_bit_sequencer_top i2cms_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .busy_res  (result.busy_res),
  .done_res  (result.done_res),
  .rejected  (result.rejected)
);
